// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");
`else
`define ASSERT_PROP(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

// ===== hdl/amte_pkg.sv =====
package amte_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [2:0] {
        ACT_IDENT     = 3'd0,
        ACT_SCALE     = 3'd1,
        ACT_ROTATE    = 3'd2,
        ACT_TRANSLATE = 3'd3,
        ACT_TRANSFORM = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        A_ONE,
        A_VAL,
        A_COS,
        A_SIN
    } t_asel;

    typedef enum logic [1:0] {
        B_ONE,
        B_MAT,
        B_SAVE
    } t_bsel;

    typedef struct packed {
        logic       issue;
        t_asel      a_sel;
        logic [1:0] vsel;
        t_bsel      b_sel;
        logic [3:0] idx;
        logic       save;
        logic       clear;
        logic       sub;
        logic       last;
        logic [3:0] dst;
    } t_term;

    function automatic logic [29:0] atan_lut(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'h20000000;
            5'd1:  v = 30'h12E4051D;
            5'd2:  v = 30'h09FB385B;
            5'd3:  v = 30'h051111D4;
            5'd4:  v = 30'h028B0D43;
            5'd5:  v = 30'h0145D7E1;
            5'd6:  v = 30'h00A2F61E;
            5'd7:  v = 30'h00517C55;
            5'd8:  v = 30'h0028BE53;
            5'd9:  v = 30'h00145F2E;
            5'd10: v = 30'h000A2F98;
            5'd11: v = 30'h000517CC;
            5'd12: v = 30'h00028BE6;
            5'd13: v = 30'h000145F3;
            5'd14: v = 30'h0000A2F9;
            5'd15: v = 30'h0000517C;
            5'd16: v = 30'h000028BE;
            5'd17: v = 30'h0000145F;
            5'd18: v = 30'h00000A2F;
            5'd19: v = 30'h00000517;
            5'd20: v = 30'h0000028B;
            5'd21: v = 30'h00000145;
            5'd22: v = 30'h000000A2;
            5'd23: v = 30'h00000051;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/amte_cordic.sv =====
module amte_cordic
    import amte_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [15:0]         i_angle,
    output logic                o_done,
    output logic signed [17:0]  o_sin,
    output logic signed [17:0]  o_cos
);

    localparam int SW = $clog2(CORDIC_STEPS + 1);

    logic signed [33:0] r_x, r_y, r_z;
    logic               r_flip;
    logic               r_busy;
    logic               r_done;
    logic [SW-1:0]      r_i;

    logic signed [33:0] w_z0, w_dx, w_dy, w_at;
    logic signed [33:0] w_cr, w_sr;
    logic signed [19:0] w_c20, w_s20;
    logic signed [17:0] w_cc, w_sc;

    always_comb begin
        w_z0 = $signed({{2{i_angle[15]}}, i_angle, 16'b0});
        w_dx = r_y >>> r_i;
        w_dy = r_x >>> r_i;
        w_at = $signed({4'b0, atan_lut(5'(r_i))});
        w_cr = (r_x + 34'sd8192) >>> 14;
        w_sr = (r_y + 34'sd8192) >>> 14;
        w_c20 = w_cr[19:0];
        w_s20 = w_sr[19:0];
        if (w_c20 > 20'sd65536) begin
            w_cc = 18'sd65536;
        end else if (w_c20 < -20'sd65536) begin
            w_cc = -18'sd65536;
        end else begin
            w_cc = w_c20[17:0];
        end
        if (w_s20 > 20'sd65536) begin
            w_sc = 18'sd65536;
        end else if (w_s20 < -20'sd65536) begin
            w_sc = -18'sd65536;
        end else begin
            w_sc = w_s20[17:0];
        end
    end

    assign o_cos  = r_flip ? -w_cc : w_cc;
    assign o_sin  = r_flip ? -w_sc : w_sc;
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_i == SW'(CORDIC_STEPS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == SW'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= CORDIC_GAIN;
            r_y <= '0;
            if ($signed(i_angle) > 16'sd16384) begin
                r_z    <= w_z0 - 34'sh0_8000_0000;
                r_flip <= 1'b1;
            end else if ($signed(i_angle) < -16'sd16384) begin
                r_z    <= w_z0 + 34'sh0_8000_0000;
                r_flip <= 1'b1;
            end else begin
                r_z    <= w_z0;
                r_flip <= 1'b0;
            end
        end else if (r_busy) begin
            if (!r_z[33]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_at;
            end
        end
    end

endmodule

// ===== hdl/affine_matrix_transform_engine.sv =====
// Channel   Direction  Handshake          Payload
// input     in         i_valid/o_ready    i_action, i_value_x/y/z, i_angle_x/y/z, i_last_vertex
// result    out        o_valid/i_ready    o_world_x/y/z, o_last_out, o_overflow
//
// Every product goes through one shared 32x32 multiplier, one term per cycle.
// A vertex runs 12 terms in ST_RUN, then ST_DRAIN, then the output load in ST_OUT.
// Scale, translate and rotate write the matrix back through ST_RUN and ST_DRAIN; rotate
// first runs the CORDIC once per angle, and identity loads the matrix on accept.
// Reset loads the identity matrix; a stalled result holds the engine in ST_OUT.
`include "assert_macros.svh"

module affine_matrix_transform_engine
    import amte_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_action,
    input  logic signed [31:0] i_value_x,
    input  logic signed [31:0] i_value_y,
    input  logic signed [31:0] i_value_z,
    input  logic [15:0]        i_angle_x,
    input  logic [15:0]        i_angle_y,
    input  logic [15:0]        i_angle_z,
    input  logic               i_last_vertex,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_world_x,
    output logic signed [31:0] o_world_y,
    output logic signed [31:0] o_world_z,
    output logic               o_last_out,
    output logic               o_overflow
);

    t_state             r_state, n_state;
    logic [2:0]         r_action;
    logic [5:0]         r_step;
    logic [5:0]         w_last_step;
    logic signed [31:0] r_v [3];
    logic [15:0]        r_ang [3];
    logic signed [17:0] r_cos [3];
    logic signed [17:0] r_sin [3];
    logic [1:0]         r_ang_idx;
    logic               r_cstart;
    logic               r_last;
    logic signed [31:0] r_m [12];
    logic               r_mat_ovf;
    logic               r_vovf;
    logic signed [31:0] r_w [3];
    logic signed [31:0] r_save;
    logic signed [63:0] r_prod;
    logic               r_pv;
    t_term              r_pt;
    logic signed [50:0] r_acc;
    logic               r_o_valid;

    t_term              w_term;
    logic               w_accept;
    logic               w_issue;
    logic [15:0]        w_angle;
    logic               w_cdone;
    logic signed [17:0] w_sin, w_cos;
    logic signed [31:0] w_a, w_b;
    logic signed [17:0] w_trig;
    logic signed [63:0] w_rnd64;
    logic signed [50:0] w_rp, w_base, w_sum;
    logic signed [31:0] w_sat;
    logic               w_of;
    logic [1:0]         w_rr, w_cc, w_t, w_p, w_q;
    logic [1:0]         w_rot;

    amte_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cstart),
        .i_angle (w_angle),
        .o_done  (w_cdone),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    always_comb begin
        case (r_ang_idx)
            2'd0:    w_angle = r_ang[0];
            2'd1:    w_angle = r_ang[1];
            default: w_angle = r_ang[2];
        endcase
    end

    // Term sequencer: at most one multiply term per step for the current action.
    always_comb begin
        w_term      = '0;
        w_last_step = 6'd0;
        w_rr        = r_step[3:2];
        w_cc        = r_step[1:0];
        w_t         = r_step[1:0];
        w_rot       = r_step[5:4];
        w_p         = 2'd0;
        w_q         = 2'd0;
        unique case (r_action)
            ACT_SCALE: begin
                w_last_step   = 6'd11;
                w_term.issue  = (w_cc != 2'd3);
                w_term.a_sel  = A_VAL;
                w_term.vsel   = w_rr;
                w_term.b_sel  = B_MAT;
                w_term.idx    = 4'(3 * int'(w_rr) + int'(w_cc));
                w_term.clear  = 1'b1;
                w_term.last   = 1'b1;
                w_term.dst    = w_term.idx;
            end
            ACT_TRANSLATE: begin
                w_last_step  = 6'd5;
                w_cc         = r_step[2:1];
                w_term.issue = 1'b1;
                if (!r_step[0]) begin
                    w_term.a_sel = A_ONE;
                    w_term.b_sel = B_MAT;
                    w_term.idx   = 4'(9 + int'(w_cc));
                    w_term.clear = 1'b1;
                end else begin
                    w_term.a_sel = A_VAL;
                    w_term.vsel  = w_cc;
                    w_term.b_sel = B_ONE;
                    w_term.last  = 1'b1;
                    w_term.dst   = 4'(9 + int'(w_cc));
                end
            end
            ACT_TRANSFORM: begin
                w_last_step  = 6'd11;
                w_cc         = r_step[3:2];
                w_term.issue = 1'b1;
                w_term.b_sel = B_MAT;
                w_term.dst   = {2'b0, w_cc};
                if (w_t == 2'd0) begin
                    w_term.a_sel = A_ONE;
                    w_term.idx   = 4'(9 + int'(w_cc));
                    w_term.clear = 1'b1;
                end else begin
                    w_term.a_sel = A_VAL;
                    w_term.vsel  = w_t - 2'd1;
                    w_term.idx   = 4'(3 * (int'(w_t) - 1) + int'(w_cc));
                    w_term.last  = (w_t == 2'd3);
                end
            end
            ACT_ROTATE: begin
                w_last_step  = 6'd47;
                w_term.issue = 1'b1;
                w_term.vsel  = w_rot;
                case (w_rot)
                    2'd0:    begin w_p = 2'd1; w_q = 2'd2; end
                    2'd1:    begin w_p = 2'd0; w_q = 2'd2; end
                    default: begin w_p = 2'd0; w_q = 2'd1; end
                endcase
                case (w_t)
                    2'd0: begin
                        w_term.a_sel = A_COS;
                        w_term.b_sel = B_MAT;
                        w_term.idx   = 4'(3 * int'(w_rr) + int'(w_p));
                        w_term.save  = 1'b1;
                        w_term.clear = 1'b1;
                    end
                    2'd1: begin
                        w_term.a_sel = A_SIN;
                        w_term.b_sel = B_MAT;
                        w_term.idx   = 4'(3 * int'(w_rr) + int'(w_q));
                        w_term.sub   = 1'b1;
                        w_term.last  = 1'b1;
                        w_term.dst   = 4'(3 * int'(w_rr) + int'(w_p));
                    end
                    2'd2: begin
                        w_term.a_sel = A_SIN;
                        w_term.b_sel = B_SAVE;
                        w_term.clear = 1'b1;
                    end
                    default: begin
                        w_term.a_sel = A_COS;
                        w_term.b_sel = B_MAT;
                        w_term.idx   = 4'(3 * int'(w_rr) + int'(w_q));
                        w_term.last  = 1'b1;
                        w_term.dst   = w_term.idx;
                    end
                endcase
            end
            default: begin
                w_term = '0;
            end
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        case (w_term.vsel)
            2'd0:    w_trig = (w_term.a_sel == A_COS) ? r_cos[0] : r_sin[0];
            2'd1:    w_trig = (w_term.a_sel == A_COS) ? r_cos[1] : -r_sin[1];
            default: w_trig = (w_term.a_sel == A_COS) ? r_cos[2] : r_sin[2];
        endcase
        case (w_term.a_sel)
            A_ONE: w_a = ONE_Q16;
            A_VAL: begin
                case (w_term.vsel)
                    2'd0:    w_a = r_v[0];
                    2'd1:    w_a = r_v[1];
                    default: w_a = r_v[2];
                endcase
            end
            default: w_a = 32'(w_trig);
        endcase
        case (w_term.b_sel)
            B_MAT:   w_b = r_m[w_term.idx];
            B_SAVE:  w_b = r_save;
            default: w_b = ONE_Q16;
        endcase
    end

    // Accumulate stage: round the product to Q16.16, sum, saturate.
    always_comb begin
        w_rnd64 = (r_prod + 64'sd32768) >>> 16;
        w_rp    = w_rnd64[50:0];
        w_base  = r_pt.clear ? 51'sd0 : r_acc;
        w_sum   = r_pt.sub ? (w_base - w_rp) : (w_base + w_rp);
        if (w_sum > 51'sd2147483647) begin
            w_sat = 32'sh7FFF_FFFF;
            w_of  = 1'b1;
        end else if (w_sum < -51'sd2147483648) begin
            w_sat = 32'sh8000_0000;
            w_of  = 1'b1;
        end else begin
            w_sat = w_sum[31:0];
            w_of  = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_action) inside
                        ACT_SCALE, ACT_TRANSLATE, ACT_TRANSFORM: n_state = ST_RUN;
                        ACT_ROTATE: n_state = ST_CORDIC;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CORDIC: begin
                if (w_cdone && r_ang_idx == 2'd2) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_step == w_last_step) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = (r_action == ACT_TRANSFORM) ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                if (!r_o_valid || i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready  = (r_state == ST_IDLE);
        w_accept = i_valid && o_ready;
        w_issue  = (r_state == ST_RUN) && w_term.issue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= '0;
            r_ang_idx <= '0;
            r_cstart  <= 1'b0;
            r_pv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cstart <= (w_accept && (i_action == ACT_ROTATE)) ||
                        (w_cdone && (r_ang_idx != 2'd2));
            r_pv     <= w_issue;
            if (w_accept) begin
                r_step    <= '0;
                r_ang_idx <= '0;
            end
            if (r_state == ST_RUN) begin
                r_step <= r_step + 6'd1;
            end
            if (w_cdone) begin
                r_ang_idx <= r_ang_idx + 2'd1;
            end
            if (r_state == ST_OUT && (!r_o_valid || i_ready)) begin
                r_o_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_action;
            r_v[0]   <= i_value_x;
            r_v[1]   <= i_value_y;
            r_v[2]   <= i_value_z;
            r_ang[0] <= i_angle_x;
            r_ang[1] <= i_angle_y;
            r_ang[2] <= i_angle_z;
            r_last   <= i_last_vertex;
            r_vovf   <= 1'b0;
        end
        if (w_cdone) begin
            r_cos[r_ang_idx] <= w_cos;
            r_sin[r_ang_idx] <= w_sin;
        end
        if (w_issue) begin
            r_prod <= w_a * w_b;
            r_pt   <= w_term;
            if (w_term.save) begin
                r_save <= r_m[w_term.idx];
            end
        end
        if (r_pv) begin
            r_acc <= w_sum;
            if (r_pt.last && r_action == ACT_TRANSFORM) begin
                r_w[r_pt.dst[1:0]] <= w_sat;
                r_vovf <= r_vovf | w_of;
            end
        end
        if (r_state == ST_OUT && (!r_o_valid || i_ready)) begin
            o_world_x  <= r_w[0];
            o_world_y  <= r_w[1];
            o_world_z  <= r_w[2];
            o_last_out <= r_last;
            o_overflow <= r_vovf | r_mat_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_accept && i_action == ACT_IDENT)) begin
            for (int k = 0; k < 12; k++) begin
                r_m[k] <= ((k == 0) || (k == 4) || (k == 8)) ? ONE_Q16 : 32'sd0;
            end
            r_mat_ovf <= 1'b0;
        end else if (r_pv && r_pt.last && r_action != ACT_TRANSFORM) begin
            r_m[r_pt.dst] <= w_sat;
            r_mat_ovf     <= r_mat_ovf | w_of;
        end
    end

    assign o_valid = r_o_valid;

    `ASSERT_PROP(a_ident_clears, i_clk, i_rst_n, (w_accept && i_action == ACT_IDENT) |=> !r_mat_ovf)
    `ASSERT_PROP(a_run_drains, i_clk, i_rst_n, (r_state == ST_RUN && r_step == w_last_step) |=> (r_state == ST_DRAIN))
    `ASSERT_PROP(a_cdone_state, i_clk, i_rst_n, w_cdone |-> (r_state == ST_CORDIC))

endmodule

// ===== dv/tb_affine_matrix_transform_engine.sv =====
`timescale 1ns / 100ps

module tb_affine_matrix_transform_engine;
    import amte_pkg::*;

    typedef struct {
        logic [2:0]         action;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic [15:0]        ax;
        logic [15:0]        ay;
        logic [15:0]        az;
        logic               last;
    } t_cmd;

    typedef struct {
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic signed [31:0] wz;
        logic               last;
        logic               ovf;
    } t_world;

    localparam longint ARC_TURNS [24] = '{
        64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
        64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
        64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
    };
    localparam int WATCHDOG_LIMIT = 5000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [2:0]         i_action;
    logic signed [31:0] i_value_x;
    logic signed [31:0] i_value_y;
    logic signed [31:0] i_value_z;
    logic [15:0]        i_angle_x;
    logic [15:0]        i_angle_y;
    logic [15:0]        i_angle_z;
    logic               i_last_vertex;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_world_x;
    logic signed [31:0] o_world_y;
    logic signed [31:0] o_world_z;
    logic               o_last_out;
    logic               o_overflow;

    logic signed [31:0] model_mat [12];
    logic               model_ovf;
    t_world             world_q [$];
    int                 errors;
    int                 hold_left;
    bit                 idle_on;
    int                 stall_count;

    affine_matrix_transform_engine u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_value_x     (i_value_x),
        .i_value_y     (i_value_y),
        .i_value_z     (i_value_z),
        .i_angle_x     (i_angle_x),
        .i_angle_y     (i_angle_y),
        .i_angle_z     (i_angle_z),
        .i_last_vertex (i_last_vertex),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_world_x     (o_world_x),
        .o_world_y     (o_world_y),
        .o_world_z     (o_world_z),
        .o_last_out    (o_last_out),
        .o_overflow    (o_overflow)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic longint fx_mul(logic signed [31:0] a, logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b) + 64'sd32768;
        return p >>> 16;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v, ref logic flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    task automatic sin_cos(input logic [15:0] ang, output logic signed [31:0] sn,
                           output logic signed [31:0] cs);
        logic signed [31:0] a32;
        longint z, x, y, dx, dy, c, s;
        bit flip;
        a32 = {ang, 16'h0000};
        z = a32;
        flip = 0;
        x = 64'sd652032874;
        y = 0;
        if (z > 64'sh40000000) begin
            z -= 64'sh80000000;
            flip = 1;
        end else if (z < -64'sh40000000) begin
            z += 64'sh80000000;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= ARC_TURNS[i];
            end else begin
                x += dx;
                y -= dy;
                z += ARC_TURNS[i];
            end
        end
        c = (x + 64'sd8192) >>> 14;
        s = (y + 64'sd8192) >>> 14;
        if (c > 65536) c = 65536;
        if (c < -65536) c = -65536;
        if (s > 65536) s = 65536;
        if (s < -65536) s = -65536;
        if (flip) begin
            c = -c;
            s = -s;
        end
        sn = s[31:0];
        cs = c[31:0];
    endtask

    task automatic mix_columns(input int p, input int q, input logic signed [31:0] c,
                               input logic signed [31:0] sp, input logic signed [31:0] sq);
        logic signed [31:0] mp, mq;
        for (int r = 0; r < 4; r++) begin
            mp = model_mat[r*3+p];
            mq = model_mat[r*3+q];
            model_mat[r*3+p] = clamp32(fx_mul(mp, c) - fx_mul(mq, sq), model_ovf);
            model_mat[r*3+q] = clamp32(fx_mul(mp, sp) + fx_mul(mq, c), model_ovf);
        end
    endtask

    task automatic load_unit_matrix();
        foreach (model_mat[k]) model_mat[k] = '0;
        model_mat[0] = ONE_Q16;
        model_mat[4] = ONE_Q16;
        model_mat[8] = ONE_Q16;
        model_ovf = 1'b0;
    endtask

    task automatic apply_command(input t_cmd c);
        logic signed [31:0] v [3];
        logic signed [31:0] sn, cs;
        logic               of;
        longint             acc;
        t_world             w;
        logic signed [31:0] res [3];
        v[0] = c.vx;
        v[1] = c.vy;
        v[2] = c.vz;
        of = 1'b0;
        case (c.action)
            ACT_IDENT: load_unit_matrix();
            ACT_SCALE: begin
                for (int r = 0; r < 3; r++)
                    for (int k = 0; k < 3; k++)
                        model_mat[r*3+k] = clamp32(fx_mul(v[r], model_mat[r*3+k]), model_ovf);
            end
            ACT_ROTATE: begin
                sin_cos(c.ax, sn, cs);
                mix_columns(1, 2, cs, sn, sn);
                sin_cos(c.ay, sn, cs);
                mix_columns(0, 2, cs, -sn, -sn);
                sin_cos(c.az, sn, cs);
                mix_columns(0, 1, cs, sn, sn);
            end
            ACT_TRANSLATE: begin
                for (int k = 0; k < 3; k++)
                    model_mat[9+k] = clamp32(longint'(model_mat[9+k]) + longint'(v[k]),
                                             model_ovf);
            end
            ACT_TRANSFORM: begin
                for (int k = 0; k < 3; k++) begin
                    acc = model_mat[9+k];
                    for (int r = 0; r < 3; r++) acc += fx_mul(v[r], model_mat[r*3+k]);
                    res[k] = clamp32(acc, of);
                end
                w.wx = res[0];
                w.wy = res[1];
                w.wz = res[2];
                w.last = c.last;
                w.ovf = of | model_ovf;
                world_q.push_back(w);
            end
            default: ;
        endcase
    endtask

    // Sender: returns at a falling edge with valid still high; the caller drives next.
    task automatic send_word(input t_cmd c);
        if (idle_on && $urandom_range(99) < 31) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_action      <= c.action;
        i_value_x     <= c.vx;
        i_value_y     <= c.vy;
        i_value_z     <= c.vz;
        i_angle_x     <= c.ax;
        i_angle_y     <= c.ay;
        i_angle_z     <= c.az;
        i_last_vertex <= c.last;
        do @(posedge i_clk); while (!o_ready);
        apply_command(c);
        @(negedge i_clk);
    endtask

    task automatic stop_sending();
        i_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic t_cmd make_cmd(logic [2:0] a, logic signed [31:0] x,
                                      logic signed [31:0] y, logic signed [31:0] z,
                                      logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                                      logic last);
        t_cmd c;
        c.action = a;
        c.vx = x;
        c.vy = y;
        c.vz = z;
        c.ax = ax;
        c.ay = ay;
        c.az = az;
        c.last = last;
        return c;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        if ($urandom_range(7) == 0) return $urandom;
        return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    endfunction

    function automatic logic signed [31:0] rand_factor();
        if ($urandom_range(15) == 0) return $urandom;
        return $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0000_8000;
    endfunction

    function automatic t_cmd rand_cmd();
        int pick;
        t_cmd c;
        pick = $urandom_range(99);
        c = make_cmd(ACT_TRANSFORM, rand_coord(), rand_coord(), rand_coord(),
                     16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom_range(1)));
        if (pick < 8) begin
            c.action = ACT_IDENT;
        end else if (pick < 18) begin
            c.action = ACT_SCALE;
            c.vx = rand_factor();
            c.vy = rand_factor();
            c.vz = rand_factor();
        end else if (pick < 30) begin
            c.action = ACT_ROTATE;
        end else if (pick < 40) begin
            c.action = ACT_TRANSLATE;
        end else if (pick < 45) begin
            c.action = 3'($urandom_range(5, 7));
        end
        return c;
    endfunction

    task automatic test_directed();
        logic [15:0] angles [6] = '{16'h0000, 16'h4000, 16'h4001, 16'h8000, 16'hC000, 16'hBFFF};
        send_word(make_cmd(ACT_TRANSFORM, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000,
                           '0, '0, '0, 1'b1));
        send_word(make_cmd(ACT_TRANSFORM, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0,
                           '0, '0, '0, 1'b0));
        for (int k = 0; k < 6; k++) begin
            send_word(make_cmd(ACT_ROTATE, '0, '0, '0, angles[k], angles[(k+1)%6],
                               angles[(k+2)%6], 1'b0));
            send_word(make_cmd(ACT_TRANSFORM, 32'sh0001_8000, 32'shFFFE_0000, 32'sh0003_0000,
                               '0, '0, '0, 1'b1));
        end
        send_word(make_cmd(ACT_IDENT, '0, '0, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
        send_word(make_cmd(ACT_SCALE, 32'sh0002_0000, 32'shFFFF_8000, 32'sh0000_0001,
                           '0, '0, '0, 1'b0));
        send_word(make_cmd(ACT_TRANSLATE, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_1234,
                           '0, '0, '0, 1'b0));
        send_word(make_cmd(ACT_TRANSFORM, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
                           '0, '0, '0, 1'b1));
        send_word(make_cmd(ACT_TRANSLATE, 32'sh7FFF_FFFF, '0, '0, '0, '0, '0, 1'b0));
        send_word(make_cmd(ACT_TRANSFORM, '0, '0, '0, '0, '0, '0, 1'b0));
        for (int a = 5; a < 8; a++)
            send_word(make_cmd(3'(a), 32'sh0005_0000, 32'sh0005_0000, 32'sh0005_0000,
                               16'h1000, 16'h2000, 16'h3000, 1'b1));
        send_word(make_cmd(ACT_IDENT, '0, '0, '0, '0, '0, '0, 1'b0));
        send_word(make_cmd(ACT_SCALE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                           '0, '0, '0, 1'b0));
        send_word(make_cmd(ACT_TRANSFORM, 32'sh0000_FFFF, 32'shFFFF_FFFF, 32'sh0000_0001,
                           '0, '0, '0, 1'b1));
        send_word(make_cmd(ACT_IDENT, '0, '0, '0, '0, '0, '0, 1'b0));
        stop_sending();
    endtask

    task automatic test_random(input int count, input bit with_idle);
        idle_on = with_idle;
        repeat (count) send_word(rand_cmd());
        stop_sending();
        idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        hold_left = 400;
        for (int k = 0; k < 30; k++)
            send_word(make_cmd(ACT_TRANSFORM, rand_coord(), rand_coord(), rand_coord(),
                               16'($urandom), 16'($urandom), 16'($urandom),
                               1'($urandom_range(1))));
        stop_sending();
    endtask

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 1'b0;
        end else if (idle_on) begin
            i_ready <= ($urandom_range(99) >= 31);
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_world w;
        if (i_rst_n && o_valid && i_ready) begin
            if (world_q.size() == 0) begin
                $display("%0t: unexpected word x=%h y=%h z=%h", $time, o_world_x, o_world_y,
                         o_world_z);
                errors++;
            end else begin
                w = world_q.pop_front();
                if (o_world_x !== w.wx) begin
                    $display("%0t: world_x expected %h actual %h", $time, w.wx, o_world_x);
                    errors++;
                end
                if (o_world_y !== w.wy) begin
                    $display("%0t: world_y expected %h actual %h", $time, w.wy, o_world_y);
                    errors++;
                end
                if (o_world_z !== w.wz) begin
                    $display("%0t: world_z expected %h actual %h", $time, w.wz, o_world_z);
                    errors++;
                end
                if (o_last_out !== w.last) begin
                    $display("%0t: last_out expected %b actual %b", $time, w.last, o_last_out);
                    errors++;
                end
                if (o_overflow !== w.ovf) begin
                    $display("%0t: overflow expected %b actual %b", $time, w.ovf, o_overflow);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
            if (stall_count >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        errors        = 0;
        hold_left     = 0;
        idle_on       = 1'b1;
        stall_count   = 0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_ready       = 1'b0;
        i_action      = ACT_IDENT;
        i_value_x     = '0;
        i_value_y     = '0;
        i_value_z     = '0;
        i_angle_x     = '0;
        i_angle_y     = '0;
        i_angle_z     = '0;
        i_last_vertex = 1'b0;
        load_unit_matrix();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(500, 1'b1);
        test_random(300, 1'b0);
        test_backpressure();
        test_random(500, 1'b1);
        wait (world_q.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && world_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
